// ----- sv/rmj_pkg.sv -----
// Shared constants, types and saturation helper for the radar measurement Jacobian.
`default_nettype none
package rmj_pkg;

	localparam int DATA_W      = 32;
	localparam int QBITS       = 32;
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = QBITS + 1;
	localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] NEG_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] apx;
		logic [31:0] apy;
		logic [63:0] cmag;
		logic [63:0] p2;
		logic        cneg;
		logic        negx;
		logic        negy;
		logic        zero;
	} sq_side_t;

	typedef struct packed {
		logic cneg;
		logic negx;
		logic negy;
		logic zero;
	} div_side_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              sat;
	} sat_t;

	function automatic sat_t sat_apply(input logic [QBITS-1:0] q, input logic ovf,
			input logic neg);
		sat_t r;
		if (neg) begin
			if (ovf || (q > NEG_MIN)) begin
				r.val = NEG_MIN;
				r.sat = 1'b1;
			end else begin
				r.val = DATA_W'(-q);
				r.sat = 1'b0;
			end
		end else begin
			if (ovf || q[QBITS-1]) begin
				r.val = POS_MAX;
				r.sat = 1'b1;
			end else begin
				r.val = DATA_W'(q);
				r.sat = 1'b0;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/rmj_if.sv -----
// Valid/ready channel interfaces for the radar state input and the Jacobian result.
`default_nettype none
interface rmj_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface rmj_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] range_by_px;
	logic signed [31:0] range_by_py;
	logic signed [31:0] bearing_by_px;
	logic signed [31:0] bearing_by_py;
	logic signed [31:0] rate_by_px;
	logic signed [31:0] rate_by_py;
	logic               zero_range;
	logic               saturated;
	modport source (output valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
		rate_by_px, rate_by_py, zero_range, saturated, input ready);
	modport sink (input valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
		rate_by_px, rate_by_py, zero_range, saturated, output ready);
endinterface
`default_nettype wire

// ----- sv/rmj_delay.sv -----
// Enabled delay line carrying a valid bit and a side payload.
`default_nettype none
module rmj_delay #(
	parameter int W = 8,
	parameter int D = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         vld_i,
	input  wire logic [W-1:0] dat_i,
	output logic              vld_o,
	output logic [W-1:0]      dat_o
);

	logic [D-1:0] vld_s;
	logic [W-1:0] dat_s [0:D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= D'({vld_s, vld_i});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s[0] <= dat_i;
			for (int i = 1; i < D; i++) begin
				dat_s[i] <= dat_s[i-1];
			end
		end
	end

	assign vld_o = vld_s[D-1];
	assign dat_o = dat_s[D-1];

endmodule
`default_nettype wire

// ----- sv/rmj_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rmj_isqrt import rmj_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] x,
	output logic [31:0]      root
);

	logic [63:0] x_s   [0:SQRT_STAGES-1];
	logic [63:0] res_s [0:SQRT_STAGES-1];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam int SH = 62 - 2 * k;
		logic [63:0] xi, ri, bitv;
		logic [64:0] trial;
		if (k == 0) begin : g_first
			assign xi = x;
			assign ri = '0;
		end else begin : g_next
			assign xi = x_s[k-1];
			assign ri = res_s[k-1];
		end
		assign bitv  = 64'(1) << SH;
		assign trial = 65'(ri) + 65'(bitv);

		always_ff @(posedge clk) begin
			if (en) begin
				if (65'(xi) >= trial) begin
					x_s[k]   <= 64'(65'(xi) - trial);
					res_s[k] <= (ri >> 1) + bitv;
				end else begin
					x_s[k]   <= xi;
					res_s[k] <= ri >> 1;
				end
			end
		end
	end

	assign root = res_s[SQRT_STAGES-1][31:0];

endmodule
`default_nettype wire

// ----- sv/rmj_div.sv -----
// Pipelined restoring divider giving a 32-bit quotient and an overflow flag.
`default_nettype none
module rmj_div import rmj_pkg::*; #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic [QBITS-1:0]      quot,
	output logic                  ovf
);

	localparam int CW = (NUM_W > DEN_W + QBITS) ? NUM_W : DEN_W + QBITS;

	logic [NUM_W-1:0] rem_s [0:QBITS];
	logic [DEN_W-1:0] den_s [0:QBITS];
	logic [QBITS-1:0] q_s   [0:QBITS];
	logic [QBITS:0]   ovf_s;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= CW'(num) >= (CW'(den) << QBITS);
		end
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		localparam int SH = QBITS - 1 - k;
		logic [CW-1:0] dsh, rx;
		logic          ge;
		assign dsh = CW'(den_s[k]) << SH;
		assign rx  = CW'(rem_s[k]);
		assign ge  = rx >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? NUM_W'(rx - dsh) : rem_s[k];
				den_s[k+1] <= den_s[k];
				q_s[k+1]   <= ge ? (q_s[k] | (QBITS'(1) << SH)) : q_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign quot = q_s[QBITS];
	assign ovf  = ovf_s[QBITS];

endmodule
`default_nettype wire

// ----- sv/radar_measurement_jacobian.sv -----
// Radar measurement Jacobian: a valid/ready pipeline from input transfer to result valid.
// Throughput one item per cycle; a stalled output freezes the whole pipeline in place.
// Each item runs through the 32-stage square root and then the 33-stage dividers in series.
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module radar_measurement_jacobian import rmj_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rmj_in_if.sink    req,
	rmj_out_if.source rsp
);

	logic en;
	logic vld_s5;

	assign en        = !vld_s5 || rsp.ready;
	assign req.ready = en;

	logic [31:0] apx_c, apy_c;
	assign apx_c = req.pos_x[31] ? 32'(-req.pos_x) : 32'(req.pos_x);
	assign apy_c = req.pos_y[31] ? 32'(-req.pos_y) : 32'(req.pos_y);

	logic               vld_s1;
	logic [31:0]        apx_s1, apy_s1;
	logic               negx_s1, negy_s1, zero_s1;
	logic [63:0]        sqx_s1, sqy_s1;
	logic signed [63:0] cx_s1, cy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			apx_s1  <= apx_c;
			apy_s1  <= apy_c;
			negx_s1 <= req.pos_x[31];
			negy_s1 <= req.pos_y[31];
			zero_s1 <= (req.pos_x == 32'sd0) && (req.pos_y == 32'sd0);
			sqx_s1  <= 64'(apx_c) * 64'(apx_c);
			sqy_s1  <= 64'(apy_c) * 64'(apy_c);
			cx_s1   <= 64'(req.vel_x) * 64'(req.pos_y);
			cy_s1   <= 64'(req.vel_y) * 64'(req.pos_x);
		end
	end

	logic signed [64:0] diff_c;
	assign diff_c = 65'(cx_s1) - 65'(cy_s1);

	logic     vld_s2;
	sq_side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.apx  <= apx_s1;
			side_s2.apy  <= apy_s1;
			side_s2.p2   <= sqx_s1 + sqy_s1;
			side_s2.cneg <= diff_c[64];
			side_s2.cmag <= diff_c[64] ? 64'(-diff_c) : 64'(diff_c);
			side_s2.negx <= negx_s1;
			side_s2.negy <= negy_s1;
			side_s2.zero <= zero_s1;
		end
	end

	logic [31:0] root;
	logic        vld_a;
	sq_side_t    side_a;

	rmj_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.x    (side_s2.p2),
		.root (root)
	);

	rmj_delay #(.W($bits(sq_side_t)), .D(SQRT_STAGES)) u_sq_line (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s2),
		.dat_i  (side_s2),
		.vld_o  (vld_a),
		.dat_o  (side_a)
	);

	logic        vld_s3;
	logic [63:0] pl_s3, ph_s3, nxl_s3, nxh_s3, nyl_s3, nyh_s3;
	logic [31:0] r_s3, apx_s3, apy_s3;
	logic [63:0] p2_s3;
	div_side_t   fl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s3  <= 64'(side_a.p2[31:0]) * 64'(root);
			ph_s3  <= 64'(side_a.p2[63:32]) * 64'(root);
			nxl_s3 <= 64'(side_a.apx) * 64'(side_a.cmag[31:0]);
			nxh_s3 <= 64'(side_a.apx) * 64'(side_a.cmag[63:32]);
			nyl_s3 <= 64'(side_a.apy) * 64'(side_a.cmag[31:0]);
			nyh_s3 <= 64'(side_a.apy) * 64'(side_a.cmag[63:32]);
			r_s3   <= root;
			apx_s3 <= side_a.apx;
			apy_s3 <= side_a.apy;
			p2_s3  <= side_a.p2;
			fl_s3  <= '{cneg: side_a.cneg, negx: side_a.negx, negy: side_a.negy,
				zero: side_a.zero};
		end
	end

	logic        vld_s4;
	logic [95:0] dr3_s4, nx_s4, ny_s4;
	logic [31:0] r_s4, apx_s4, apy_s4;
	logic [63:0] p2_s4;
	div_side_t   fl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr3_s4 <= (96'(ph_s3) << 32) + 96'(pl_s3);
			nx_s4  <= (96'(nxh_s3) << 32) + 96'(nxl_s3);
			ny_s4  <= (96'(nyh_s3) << 32) + 96'(nyl_s3);
			r_s4   <= r_s3;
			apx_s4 <= apx_s3;
			apy_s4 <= apy_s3;
			p2_s4  <= p2_s3;
			fl_s4  <= fl_s3;
		end
	end

	logic [QBITS-1:0] q0, q1, q2, q3, q4, q5;
	logic             o0, o1, o2, o3, o4, o5;

	rmj_div #(.NUM_W(48), .DEN_W(32)) u_div_rx (
		.clk (clk), .en (en), .num ({apx_s4, 16'h0000}), .den (r_s4), .quot (q0), .ovf (o0)
	);
	rmj_div #(.NUM_W(48), .DEN_W(32)) u_div_ry (
		.clk (clk), .en (en), .num ({apy_s4, 16'h0000}), .den (r_s4), .quot (q1), .ovf (o1)
	);
	rmj_div #(.NUM_W(64), .DEN_W(64)) u_div_bx (
		.clk (clk), .en (en), .num ({apy_s4, 32'h0}), .den (p2_s4), .quot (q2), .ovf (o2)
	);
	rmj_div #(.NUM_W(64), .DEN_W(64)) u_div_by (
		.clk (clk), .en (en), .num ({apx_s4, 32'h0}), .den (p2_s4), .quot (q3), .ovf (o3)
	);
	rmj_div #(.NUM_W(112), .DEN_W(96)) u_div_vx (
		.clk (clk), .en (en), .num ({ny_s4, 16'h0000}), .den (dr3_s4), .quot (q4), .ovf (o4)
	);
	rmj_div #(.NUM_W(112), .DEN_W(96)) u_div_vy (
		.clk (clk), .en (en), .num ({nx_s4, 16'h0000}), .den (dr3_s4), .quot (q5), .ovf (o5)
	);

	logic      vld_b;
	div_side_t fl_b;

	rmj_delay #(.W($bits(div_side_t)), .D(DIV_STAGES)) u_div_line (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s4),
		.dat_i  (fl_s4),
		.vld_o  (vld_b),
		.dat_o  (fl_b)
	);

	sat_t s0, s1, s2, s3, s4, s5;
	assign s0 = sat_apply(q0, o0, fl_b.negx);
	assign s1 = sat_apply(q1, o1, fl_b.negy);
	assign s2 = sat_apply(q2, o2, !fl_b.negy);
	assign s3 = sat_apply(q3, o3, fl_b.negx);
	assign s4 = sat_apply(q4, o4, fl_b.negy != fl_b.cneg);
	assign s5 = sat_apply(q5, o5, fl_b.negx == fl_b.cneg);

	logic [31:0] rx_s5, ry_s5, bx_s5, by_s5, vx_s5, vy_s5;
	logic        zr_s5, sat_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_b.zero) begin
				rx_s5  <= '0;
				ry_s5  <= '0;
				bx_s5  <= '0;
				by_s5  <= '0;
				vx_s5  <= '0;
				vy_s5  <= '0;
				zr_s5  <= 1'b1;
				sat_s5 <= 1'b0;
			end else begin
				rx_s5  <= s0.val;
				ry_s5  <= s1.val;
				bx_s5  <= s2.val;
				by_s5  <= s3.val;
				vx_s5  <= s4.val;
				vy_s5  <= s5.val;
				zr_s5  <= 1'b0;
				sat_s5 <= s0.sat | s1.sat | s2.sat | s3.sat | s4.sat | s5.sat;
			end
		end
	end

	assign rsp.valid         = vld_s5;
	assign rsp.range_by_px   = rx_s5;
	assign rsp.range_by_py   = ry_s5;
	assign rsp.bearing_by_px = bx_s5;
	assign rsp.bearing_by_py = by_s5;
	assign rsp.rate_by_px    = vx_s5;
	assign rsp.rate_by_py    = vy_s5;
	assign rsp.zero_range    = zr_s5;
	assign rsp.saturated     = sat_s5;

endmodule
`default_nettype wire
